// ===== rtl/uht_pkg.sv =====
// shared types and constants of the unimodal histogram threshold block
`timescale 1ns / 1ps
package uht_pkg;

  localparam int BIN_W = 8;
  localparam logic [BIN_W-1:0] BIN_TOP = 8'hFF;

  // register indexes of the configuration port
  localparam logic [2:0] REG_START_MODE     = 3'd0;
  localparam logic [2:0] REG_SMOOTH         = 3'd1;
  localparam logic [2:0] REG_CUMULATIVE     = 3'd2;
  localparam logic [2:0] REG_DELETE_FIRST   = 3'd3;
  localparam logic [2:0] REG_DELETE_BIN     = 3'd4;
  localparam logic [2:0] REG_DELETE_LARGEST = 3'd5;
  localparam logic [2:0] REG_SUPPRESS_INV   = 3'd6;

  localparam logic [1:0] START_PEAK = 2'd0;
  localparam logic [1:0] START_BIN1 = 2'd1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_STRANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  localparam logic OP_ACCUM = 1'b0;

  localparam logic [7:0] PIX_WHITE = 8'hFF;
  localparam logic [7:0] PIX_BLACK = 8'h00;

  localparam logic [8:0] DEL_NONE = 9'h1FF;

  typedef struct packed {
    logic [1:0] start_mode;
    logic       smooth_enable;
    logic       cumulative_enable;
    logic       delete_first_enable;
    logic [8:0] delete_bin_index;
    logic       delete_largest_enable;
    logic       no_mirror;
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic [BIN_W-1:0] threshold;
    logic             inverted;
    logic [1:0]       status;
  } srch_res_t;

endpackage

// ===== rtl/unimodal_histogram_threshold_top.sv =====
// Unimodal histogram threshold: channels, configuration and histogram accumulation
//
// Input transactions with opcode 0 count a pixel into a 256-bin histogram, each by a
// registered read, then a saturating write-back. A pixel with last set then starts the
// threshold search: four passes over the bins, three multiply-adds and a corner scan
// of each bin from the start bin to the last non-zero bin. The multiply-adds and the
// scan share one multiply-add unit, and in_stall stays high while the search runs.
// The search ends with one threshold report on the output channel; the threshold is
// held for binarizing and the histogram is cleared through its valid bits.
// Input transactions with opcode 1 give one binarized pixel each, one per cycle unless stalled.
// Results sit in an output register; accumulate transactions are still taken while a
// result waits, a binarize or last pixel waits until the output register frees.
// Configuration writes are taken at any time and must come while the block is idle.
// Synchronous reset clears the histogram, the held threshold and the registers.
`timescale 1ns / 1ps
module unimodal_histogram_threshold_top #(
  parameter int COUNT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_pixel,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_result_kind,
  output logic [7:0] out_threshold,
  output logic       out_inverted,
  output logic [1:0] out_status,
  output logic [7:0] out_binary_pixel,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_wdata
);
  import uht_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_ACC  = 3'b010,
    T_SRCH = 3'b100
  } tstate_t;

  tstate_t state_r;
  cfg_t    cfg_r;

  logic [BIN_W-1:0] held_thr_r;
  logic             held_inv_r;
  logic [BIN_W-1:0] px_r;
  logic             last_r;

  logic             out_valid_r;
  logic             out_kind_r;
  logic [7:0]       out_thr_r;
  logic             out_inv_r;
  logic [1:0]       out_status_r;
  logic [7:0]       out_bin_r;

  logic             accept;
  logic             out_take;
  logic             hist_we;
  logic [BIN_W-1:0] hist_rd_addr;
  logic [BIN_W-1:0] srch_addr;
  logic [COUNT_BITS-1:0] hist_rd_data;
  logic [COUNT_BITS-1:0] hist_wr_data;
  srch_res_t        srch_res;
  logic             srch_start;
  logic [7:0]       bin_pix;

  assign out_take = out_valid_r && !out_stall;
  // accumulate transactions produce nothing, so only result-bearing ones wait on the output
  assign in_stall = (state_r != T_IDLE) ||
                    (out_valid_r && out_stall && (in_opcode || in_last));
  assign accept   = in_valid && !in_stall;

  assign hist_rd_addr = (state_r == T_SRCH) ? srch_addr : in_pixel;
  assign hist_we      = (state_r == T_ACC);
  assign hist_wr_data = (hist_rd_data == '1) ? hist_rd_data : hist_rd_data + 1'b1;
  assign srch_start   = (state_r == T_ACC) && last_r;

  uht_hist #(.CB(COUNT_BITS)) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (srch_res.done),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rd_data),
    .wr_en   (hist_we),
    .wr_addr (px_r),
    .wr_data (hist_wr_data)
  );

  uht_search #(.CB(COUNT_BITS)) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (srch_start),
    .cfg       (cfg_r),
    .hist_addr (srch_addr),
    .hist_data (hist_rd_data),
    .res       (srch_res)
  );

  always_comb begin
    if (held_inv_r) begin
      bin_pix = (in_pixel < held_thr_r) ? PIX_BLACK : PIX_WHITE;
    end else begin
      bin_pix = (in_pixel > held_thr_r) ? PIX_BLACK : PIX_WHITE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_mode            <= START_PEAK;
      cfg_r.smooth_enable         <= 1'b0;
      cfg_r.cumulative_enable     <= 1'b0;
      cfg_r.delete_first_enable   <= 1'b0;
      cfg_r.delete_bin_index      <= DEL_NONE;
      cfg_r.delete_largest_enable <= 1'b0;
      cfg_r.no_mirror             <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_MODE:     cfg_r.start_mode            <= cfg_wdata[1:0];
        REG_SMOOTH:         cfg_r.smooth_enable         <= cfg_wdata[0];
        REG_CUMULATIVE:     cfg_r.cumulative_enable     <= cfg_wdata[0];
        REG_DELETE_FIRST:   cfg_r.delete_first_enable   <= cfg_wdata[0];
        REG_DELETE_BIN:     cfg_r.delete_bin_index      <= cfg_wdata;
        REG_DELETE_LARGEST: cfg_r.delete_largest_enable <= cfg_wdata[0];
        REG_SUPPRESS_INV:   cfg_r.no_mirror             <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      held_thr_r  <= '0;
      held_inv_r  <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (accept) begin
            if (in_opcode == OP_ACCUM) begin
              px_r    <= in_pixel;
              last_r  <= in_last;
              state_r <= T_ACC;
            end else begin
              out_valid_r  <= 1'b1;
              out_kind_r   <= KIND_PIXEL;
              out_thr_r    <= held_thr_r;
              out_inv_r    <= held_inv_r;
              out_status_r <= ST_OK;
              out_bin_r    <= bin_pix;
            end
          end
        end
        T_ACC: state_r <= last_r ? T_SRCH : T_IDLE;
        T_SRCH: begin
          if (srch_res.done) begin
            held_thr_r   <= srch_res.threshold;
            held_inv_r   <= srch_res.inverted;
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_REPORT;
            out_thr_r    <= srch_res.threshold;
            out_inv_r    <= srch_res.inverted;
            out_status_r <= srch_res.status;
            out_bin_r    <= PIX_BLACK;
            state_r      <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_threshold    = out_thr_r;
  assign out_inverted     = out_inv_r;
  assign out_status       = out_status_r;
  assign out_binary_pixel = out_bin_r;

`ifndef NO_ASSERTIONS
  a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    srch_res.done |-> state_r == T_SRCH)
    else $error("search finished outside of search state");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == T_SRCH |-> !hist_we)
    else $error("histogram written during search");

  a_accum_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_opcode == OP_ACCUM |=> state_r == T_ACC)
    else $error("accumulate transaction did not reach write-back");

  a_error_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_REPORT && out_status_r != ST_OK
      |-> out_thr_r == '0 && !out_inv_r)
    else $error("error report carries a threshold");
`endif

endmodule

// ===== rtl/uht_hist.sv =====
// histogram memory with per-bin valid bits and registered read
`timescale 1ns / 1ps
module uht_hist #(
  parameter int CB = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,
  input  logic [uht_pkg::BIN_W-1:0] rd_addr,
  output logic [CB-1:0]             rd_data,
  input  logic                      wr_en,
  input  logic [uht_pkg::BIN_W-1:0] wr_addr,
  input  logic [CB-1:0]             wr_data
);
  import uht_pkg::*;

  logic [CB-1:0] mem [0:(1<<BIN_W)-1];
  logic [(1<<BIN_W)-1:0] valid_r;
  logic [CB-1:0] data_r;
  logic          vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    data_r <= mem[rd_addr];
  end

  // a bin that was never written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      vld_r <= valid_r[rd_addr];
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = vld_r ? data_r : '0;

endmodule

// ===== rtl/uht_mac.sv =====
// shared two-stage multiply-add unit: y = a * b + c
`timescale 1ns / 1ps
module uht_mac #(
  parameter int CB = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic signed [8:0]    a,
  input  logic signed [CB:0]   b,
  input  logic signed [CB+11:0] c,
  output logic                 done,
  output logic signed [CB+11:0] y
);
  import uht_pkg::*;

  logic signed [CB+9:0]  prod_r;
  logic signed [CB+11:0] c_r;
  logic signed [CB+11:0] y_r;
  logic                  v1_r;
  logic                  v2_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    c_r    <= c;
    y_r    <= {{2{prod_r[CB+9]}}, prod_r} + c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
    end
  end

  assign done = v2_r;
  assign y    = y_r;

endmodule

// ===== rtl/uht_search.sv =====
// threshold search sequencer: histogram passes and corner scan on the shared mac
`timescale 1ns / 1ps
module uht_search #(
  parameter int CB = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  uht_pkg::cfg_t             cfg,
  output logic [uht_pkg::BIN_W-1:0] hist_addr,
  input  logic [CB-1:0]             hist_data,
  output uht_pkg::srch_res_t        res
);
  import uht_pkg::*;

  localparam int DW = CB + 12;

  typedef enum logic [15:0] {
    S_IDLE = 16'b0000000000000001,
    S_P1   = 16'b0000000000000010,
    S_P2   = 16'b0000000000000100,
    S_P3   = 16'b0000000000001000,
    S_CHK  = 16'b0000000000010000,
    S_P4   = 16'b0000000000100000,
    S_CHK2 = 16'b0000000001000000,
    S_RDS  = 16'b0000000010000000,
    S_RDE  = 16'b0000000100000000,
    S_RDY  = 16'b0000001000000000,
    S_C1   = 16'b0000010000000000,
    S_C2   = 16'b0000100000000000,
    S_C3   = 16'b0001000000000000,
    S_SRD  = 16'b0010000000000000,
    S_SMUL = 16'b0100000000000000,
    S_REP  = 16'b1000000000000000
  } state_t;

  state_t state_r;

  logic [CB-1:0] w_mem [0:(1<<BIN_W)-1];
  logic [CB-1:0] f_mem [0:(1<<BIN_W)-1];
  logic [CB-1:0] w_rd_r;
  logic [CB-1:0] f_rd_r;

  logic [BIN_W-1:0] cnt_r, pidx_r;
  logic             iss_r, pv_r;
  logic [CB-1:0]    prev_r;
  logic [BIN_W-1:0] first_nz_r;
  logic             any_r;
  logic [BIN_W-1:0] lg_r;
  logic [CB-1:0]    lgv_r;
  logic             lg_done_r;
  logic [BIN_W-1:0] pk_lo_r, pk_hi_r, fnz_r, lnz_r;
  logic [CB-1:0]    pkv_r;
  logic             fnd_r;
  logic             mirror_r;
  logic [BIN_W-1:0] st_r, end_r;
  logic             end_v_r;
  logic [CB-1:0]    ys_r, ye_r;
  logic signed [DW-1:0] cc_r, acc_r;
  logic [BIN_W-1:0] i_r, best_r;
  logic [DW-1:0]    bestd_r;
  logic             best_v_r;
  logic             pend_r;
  logic [BIN_W-1:0] thr_r;
  logic             inv_r;
  logic [1:0]       status_r;

  logic             desc;
  logic             last_idx;
  logic [BIN_W-1:0] pidx_o;
  logic             del_hit;
  logic [CB-1:0]    mv;
  logic [CB-1:0]    add_a;
  logic [CB:0]      sum;
  logic [CB-1:0]    sat_v;
  logic [CB-1:0]    s1, g4;
  logic [BIN_W-1:0] w_addr, f_addr;
  logic [BIN_W-1:0] e_idx;
  logic             mirror_n;
  logic [BIN_W-1:0] st_n;
  logic signed [CB:0] dy;
  logic             mac_go, mac_done;
  logic signed [8:0]  mac_a;
  logic signed [CB:0] mac_b;
  logic signed [DW-1:0] mac_c, mac_y;
  logic [DW-1:0]    absd;
  logic             better;
  logic [BIN_W-1:0] best_fin;

  assign desc     = (state_r == S_P1) || (state_r == S_P4);
  assign last_idx = pv_r && (pidx_r == (desc ? '0 : BIN_TOP));
  assign pidx_o   = mirror_r ? ~pidx_r : pidx_r;

  // deletions act as masks on reads of the stored (optionally smoothed) copy, by original bin index
  assign del_hit = (cfg.delete_first_enable && any_r && pidx_o == first_nz_r) ||
                   (!cfg.delete_bin_index[8] && pidx_o == cfg.delete_bin_index[7:0]) ||
                   (lg_done_r && cfg.delete_largest_enable && pidx_o == lg_r);
  assign mv = del_hit ? '0 : w_rd_r;

  // one saturating adder for smoothing and suffix sums
  assign add_a = (state_r == S_P1) ? hist_data : mv;
  assign sum   = {1'b0, add_a} + {1'b0, prev_r};
  assign sat_v = sum[CB] ? '1 : sum[CB-1:0];
  assign s1    = cfg.smooth_enable ? sat_v : hist_data;
  assign g4    = cfg.cumulative_enable ? sat_v : mv;

  assign hist_addr = cnt_r;
  assign w_addr    = (state_r == S_P4 && mirror_r) ? ~cnt_r : cnt_r;
  assign e_idx     = end_r - 1'b1;

  always_comb begin
    case (state_r)
      S_RDS:          f_addr = st_r;
      S_RDE:          f_addr = e_idx;
      S_SRD, S_SMUL:  f_addr = i_r;
      default:        f_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pv_r && state_r == S_P1) begin
      w_mem[pidx_r] <= s1;
    end
    if (pv_r && state_r == S_P4) begin
      f_mem[pidx_r] <= g4;
    end
    w_rd_r <= w_mem[w_addr];
    f_rd_r <= f_mem[f_addr];
  end

  assign mirror_n = !cfg.no_mirror && ((pk_lo_r - fnz_r) > (lnz_r - pk_lo_r));

  always_comb begin
    case (cfg.start_mode)
      START_PEAK: st_n = mirror_n ? ~pk_hi_r : pk_lo_r;
      START_BIN1: st_n = 8'd1;
      default:    st_n = '0;
    endcase
  end

  assign dy = $signed({1'b0, ys_r}) - $signed({1'b0, ye_r});

  always_comb begin
    case (state_r)
      S_C1: begin
        mac_a = $signed({1'b0, st_r});
        mac_b = $signed({1'b0, ye_r});
        mac_c = '0;
      end
      S_C2: begin
        mac_a = -$signed({1'b0, e_idx});
        mac_b = $signed({1'b0, ys_r});
        mac_c = cc_r;
      end
      S_C3: begin
        mac_a = $signed({1'b0, st_r});
        mac_b = dy;
        mac_c = cc_r;
      end
      default: begin
        mac_a = $signed({1'b0, e_idx}) - $signed({1'b0, st_r});
        mac_b = $signed({1'b0, f_rd_r});
        mac_c = acc_r;
      end
    endcase
  end

  assign mac_go = ((state_r == S_C1) || (state_r == S_C2) || (state_r == S_C3) ||
                   (state_r == S_SMUL)) && !pend_r;

  uht_mac #(.CB(CB)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mac_go),
    .a     (mac_a),
    .b     (mac_b),
    .c     (mac_c),
    .done  (mac_done),
    .y     (mac_y)
  );

  assign absd     = mac_y[DW-1] ? DW'(-mac_y) : DW'(mac_y);
  assign better   = !best_v_r || (absd > bestd_r);
  assign best_fin = better ? i_r : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iss_r   <= 1'b0;
      pv_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      // address streaming shared by the four bin passes
      pv_r   <= iss_r;
      pidx_r <= cnt_r;
      if (iss_r) begin
        cnt_r <= desc ? cnt_r - 1'b1 : cnt_r + 1'b1;
        if (cnt_r == (desc ? '0 : BIN_TOP)) begin
          iss_r <= 1'b0;
        end
      end
      if (mac_go) begin
        pend_r <= 1'b1;
      end else if (mac_done) begin
        pend_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r   <= S_P1;
            cnt_r     <= BIN_TOP;
            iss_r     <= 1'b1;
            pv_r      <= 1'b0;
            prev_r    <= '0;
            any_r     <= 1'b0;
            first_nz_r <= '0;
            lg_done_r <= 1'b0;
            mirror_r  <= 1'b0;
          end
        end
        S_P1: begin
          if (pv_r) begin
            prev_r <= hist_data;
            if (s1 != '0) begin
              first_nz_r <= pidx_r;
              any_r      <= 1'b1;
            end
          end
          if (last_idx) begin
            state_r <= S_P2;
            cnt_r   <= '0;
            iss_r   <= 1'b1;
            pv_r    <= 1'b0;
            lg_r    <= '0;
            lgv_r   <= '0;
          end
        end
        S_P2: begin
          if (pv_r && mv > lgv_r) begin
            lg_r  <= pidx_r;
            lgv_r <= mv;
          end
          if (last_idx) begin
            state_r   <= S_P3;
            lg_done_r <= 1'b1;
            cnt_r     <= '0;
            iss_r     <= 1'b1;
            pv_r      <= 1'b0;
            pkv_r     <= '0;
            pk_lo_r   <= '0;
            pk_hi_r   <= '0;
            fnd_r     <= 1'b0;
            fnz_r     <= '0;
            lnz_r     <= '0;
          end
        end
        S_P3: begin
          if (pv_r) begin
            if (mv > pkv_r) begin
              pk_lo_r <= pidx_r;
              pkv_r   <= mv;
            end
            if (mv >= pkv_r) begin
              pk_hi_r <= pidx_r;
            end
            if (mv != '0) begin
              lnz_r <= pidx_r;
              if (!fnd_r) begin
                fnz_r <= pidx_r;
                fnd_r <= 1'b1;
              end
            end
          end
          if (last_idx) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (pk_lo_r < fnz_r || lnz_r < pk_lo_r) begin
            status_r <= ST_STRANGE;
            thr_r    <= '0;
            inv_r    <= 1'b0;
            state_r  <= S_REP;
          end else begin
            mirror_r <= mirror_n;
            st_r     <= st_n;
            state_r  <= S_P4;
            cnt_r    <= BIN_TOP;
            iss_r    <= 1'b1;
            pv_r     <= 1'b0;
            prev_r   <= '0;
            end_v_r  <= 1'b0;
            end_r    <= '0;
          end
        end
        S_P4: begin
          if (pv_r) begin
            prev_r <= g4;
            if (g4 != '0 && !end_v_r) begin
              end_r   <= pidx_r;
              end_v_r <= 1'b1;
            end
          end
          if (last_idx) begin
            state_r <= S_CHK2;
          end
        end
        S_CHK2: begin
          if (!end_v_r || end_r == '0 || st_r == e_idx || st_r > end_r) begin
            status_r <= ST_EMPTY;
            thr_r    <= '0;
            inv_r    <= 1'b0;
            state_r  <= S_REP;
          end else begin
            state_r <= S_RDS;
          end
        end
        S_RDS: state_r <= S_RDE;
        S_RDE: begin
          ys_r    <= f_rd_r;
          state_r <= S_RDY;
        end
        S_RDY: begin
          ye_r    <= f_rd_r;
          state_r <= S_C1;
        end
        S_C1: begin
          if (mac_done) begin
            cc_r    <= mac_y;
            state_r <= S_C2;
          end
        end
        S_C2: begin
          if (mac_done) begin
            cc_r    <= mac_y;
            state_r <= S_C3;
          end
        end
        S_C3: begin
          if (mac_done) begin
            acc_r    <= mac_y;
            i_r      <= st_r;
            best_v_r <= 1'b0;
            state_r  <= S_SRD;
          end
        end
        S_SRD: state_r <= S_SMUL;
        S_SMUL: begin
          if (mac_done) begin
            if (better) begin
              best_r   <= i_r;
              bestd_r  <= absd;
              best_v_r <= 1'b1;
            end
            // running dy * i term of the distance numerator
            acc_r <= acc_r + {{(DW-CB-1){dy[CB]}}, dy};
            if (i_r == end_r) begin
              status_r <= ST_OK;
              thr_r    <= mirror_r ? ~best_fin : best_fin;
              inv_r    <= mirror_r;
              state_r  <= S_REP;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_SRD;
            end
          end
        end
        S_REP: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res.done      = (state_r == S_REP);
  assign res.threshold = thr_r;
  assign res.inverted  = inv_r;
  assign res.status    = status_r;

endmodule
